// File: rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, character codes and the control-store program of the
// postfix character calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int VALUE_W = 32;
  localparam int PC_W    = 5;

  // Character codes.
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_C = 8'h43;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef enum logic [2:0] {
    KIND_VALUE   = 3'd0,
    KIND_WORD    = 3'd1,
    KIND_END     = 3'd2,
    KIND_OVF     = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_DIGIT, OP_NEWLINE, OP_PUSH_CLR, OP_DUP, OP_DEPTH, OP_PRINT,
    OP_LIST, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_SWAP, OP_CLEAR,
    OP_CLR_OVF, OP_COMMENT, OP_UNKNOWN
  } op_t;

  typedef enum logic [1:0] {VS_ZERO, VS_ACC, VS_RDATA} vsel_t;

  typedef enum logic [2:0] {
    AO_HOLD, AO_DIGIT, AO_ZERO, AO_ADD, AO_SUB, AO_POPW, AO_ALU
  } acc_op_t;

  typedef enum logic {PS_ACC, PS_DEPTH} psrc_t;

  typedef enum logic [1:0] {AL_MUL, AL_DIV, AL_REM} alu_op_t;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_OVF, C_LIST_DONE, C_ALU_BUSY
  } cond_t;

  // Control word: one per program step.
  typedef struct packed {
    logic            emit;
    kind_t           kind;
    vsel_t           vsel;
    logic            last;
    acc_op_t         acc_op;
    logic            push;
    psrc_t           psrc;
    logic            pop;
    logic            clr_depth;
    logic            clr_ovf;
    logic            idx_clr;
    logic            idx_inc;
    logic            rd_idx;
    logic            alu_start;
    alu_op_t         alu_op;
    cond_t           cond;
    logic [PC_W-1:0] tgt;
    logic            fin;
  } ucw_t;

  typedef struct packed {
    logic en;
    ucw_t u;
  } ctl_t;

  typedef struct packed {
    logic ovf;
    logic list_done;
  } stat_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } emit_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  // Program addresses.
  localparam logic [PC_W-1:0] S_DONE    = 5'd0;
  localparam logic [PC_W-1:0] S_DIGIT   = 5'd1;
  localparam logic [PC_W-1:0] S_NL0     = 5'd2;
  localparam logic [PC_W-1:0] S_NL1     = 5'd3;
  localparam logic [PC_W-1:0] S_COMMA   = 5'd4;
  localparam logic [PC_W-1:0] S_DUP     = 5'd5;
  localparam logic [PC_W-1:0] S_DEPTH   = 5'd6;
  localparam logic [PC_W-1:0] S_PRINT   = 5'd7;
  localparam logic [PC_W-1:0] S_CLEAR   = 5'd8;
  localparam logic [PC_W-1:0] S_CLROVF  = 5'd9;
  localparam logic [PC_W-1:0] S_UNKNOWN = 5'd10;
  localparam logic [PC_W-1:0] S_ADD0    = 5'd11;
  localparam logic [PC_W-1:0] S_ADD1    = 5'd12;
  localparam logic [PC_W-1:0] S_SUB0    = 5'd13;
  localparam logic [PC_W-1:0] S_SUB1    = 5'd14;
  localparam logic [PC_W-1:0] S_SWAP0   = 5'd15;
  localparam logic [PC_W-1:0] S_SWAP1   = 5'd16;
  localparam logic [PC_W-1:0] S_MUL0    = 5'd17;
  localparam logic [PC_W-1:0] S_MUL1    = 5'd18;
  localparam logic [PC_W-1:0] S_WAIT    = 5'd19;
  localparam logic [PC_W-1:0] S_ALU_WB  = 5'd20;
  localparam logic [PC_W-1:0] S_DIV0    = 5'd21;
  localparam logic [PC_W-1:0] S_DIV1    = 5'd22;
  localparam logic [PC_W-1:0] S_REM0    = 5'd23;
  localparam logic [PC_W-1:0] S_REM1    = 5'd24;
  localparam logic [PC_W-1:0] S_LIST0   = 5'd25;
  localparam logic [PC_W-1:0] S_LIST1   = 5'd26;
  localparam logic [PC_W-1:0] S_LIST2   = 5'd27;
  localparam logic [PC_W-1:0] S_LIST3   = 5'd28;

  // Inside a comment every byte but a newline decodes to a no-op.
  function automatic op_t decode_char(input logic [7:0] ch, input logic in_comment);
    op_t op;
    op = OP_UNKNOWN;
    if (in_comment && (ch != CH_NL)) begin
      op = OP_NOP;
    end else if ((ch >= CH_ZERO) && (ch <= CH_NINE)) begin
      op = OP_DIGIT;
    end else begin
      unique case (ch)
        CH_NL:      op = OP_NEWLINE;
        CH_SPACE:   op = OP_NOP;
        CH_COMMA:   op = OP_PUSH_CLR;
        CH_LOWER_D: op = OP_DUP;
        CH_LOWER_Z: op = OP_DEPTH;
        CH_LOWER_P: op = OP_PRINT;
        CH_LOWER_F: op = OP_LIST;
        CH_PLUS:    op = OP_ADD;
        CH_MINUS:   op = OP_SUB;
        CH_STAR:    op = OP_MUL;
        CH_SLASH:   op = OP_DIV;
        CH_PERCENT: op = OP_REM;
        CH_LOWER_R: op = OP_SWAP;
        CH_LOWER_C: op = OP_CLEAR;
        CH_UPPER_C: op = OP_CLR_OVF;
        CH_HASH:    op = OP_COMMENT;
        default:    op = OP_UNKNOWN;
      endcase
    end
    return op;
  endfunction

  function automatic logic [PC_W-1:0] entry_of(input op_t op);
    logic [PC_W-1:0] a;
    a = S_DONE;
    unique case (op)
      OP_NOP:      a = S_DONE;
      OP_DIGIT:    a = S_DIGIT;
      OP_NEWLINE:  a = S_NL0;
      OP_PUSH_CLR: a = S_COMMA;
      OP_DUP:      a = S_DUP;
      OP_DEPTH:    a = S_DEPTH;
      OP_PRINT:    a = S_PRINT;
      OP_LIST:     a = S_LIST0;
      OP_ADD:      a = S_ADD0;
      OP_SUB:      a = S_SUB0;
      OP_MUL:      a = S_MUL0;
      OP_DIV:      a = S_DIV0;
      OP_REM:      a = S_REM0;
      OP_SWAP:     a = S_SWAP0;
      OP_CLEAR:    a = S_CLEAR;
      OP_CLR_OVF:  a = S_CLROVF;
      OP_COMMENT:  a = S_DONE;
      OP_UNKNOWN:  a = S_UNKNOWN;
      default:     a = S_UNKNOWN;
    endcase
    return a;
  endfunction

  // Control store. A step that branches still performs its actions.
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t u;
    u = '0;
    unique case (pc)
      S_DONE: u.fin = 1'b1;
      S_DIGIT: begin
        u.acc_op = AO_DIGIT;
        u.fin    = 1'b1;
      end
      S_NL0: begin
        u.cond = C_NO_OVF;
        u.tgt  = S_DONE;
      end
      S_NL1: begin
        u.emit    = 1'b1;
        u.kind    = KIND_OVF;
        u.vsel    = VS_ZERO;
        u.last    = 1'b1;
        u.clr_ovf = 1'b1;
        u.fin     = 1'b1;
      end
      S_COMMA: begin
        u.push   = 1'b1;
        u.psrc   = PS_ACC;
        u.acc_op = AO_ZERO;
        u.fin    = 1'b1;
      end
      S_DUP: begin
        u.push = 1'b1;
        u.psrc = PS_ACC;
        u.fin  = 1'b1;
      end
      S_DEPTH: begin
        u.push = 1'b1;
        u.psrc = PS_DEPTH;
        u.fin  = 1'b1;
      end
      S_PRINT: begin
        u.emit = 1'b1;
        u.kind = KIND_VALUE;
        u.vsel = VS_ACC;
        u.last = 1'b1;
        u.fin  = 1'b1;
      end
      S_CLEAR: begin
        u.clr_depth = 1'b1;
        u.fin       = 1'b1;
      end
      S_CLROVF: begin
        u.clr_ovf = 1'b1;
        u.fin     = 1'b1;
      end
      S_UNKNOWN: begin
        u.emit = 1'b1;
        u.kind = KIND_UNKNOWN;
        u.vsel = VS_ZERO;
        u.last = 1'b1;
        u.fin  = 1'b1;
      end
      S_ADD0, S_SUB0, S_SWAP0, S_MUL0, S_DIV0, S_REM0: u.pop = 1'b1;
      S_ADD1: begin
        u.acc_op = AO_ADD;
        u.fin    = 1'b1;
      end
      S_SUB1: begin
        u.acc_op = AO_SUB;
        u.fin    = 1'b1;
      end
      S_SWAP1: begin
        u.push   = 1'b1;
        u.psrc   = PS_ACC;
        u.acc_op = AO_POPW;
        u.fin    = 1'b1;
      end
      S_MUL1: begin
        u.alu_start = 1'b1;
        u.alu_op    = AL_MUL;
      end
      S_WAIT: begin
        u.cond = C_ALU_BUSY;
        u.tgt  = S_WAIT;
      end
      S_ALU_WB: begin
        u.acc_op = AO_ALU;
        u.fin    = 1'b1;
      end
      S_DIV1: begin
        u.alu_start = 1'b1;
        u.alu_op    = AL_DIV;
        u.cond      = C_ALWAYS;
        u.tgt       = S_WAIT;
      end
      S_REM1: begin
        u.alu_start = 1'b1;
        u.alu_op    = AL_REM;
        u.cond      = C_ALWAYS;
        u.tgt       = S_WAIT;
      end
      S_LIST0: u.idx_clr = 1'b1;
      S_LIST1: begin
        u.rd_idx = 1'b1;
        u.cond   = C_LIST_DONE;
        u.tgt    = S_LIST3;
      end
      S_LIST2: begin
        u.emit    = 1'b1;
        u.kind    = KIND_WORD;
        u.vsel    = VS_RDATA;
        u.idx_inc = 1'b1;
        u.cond    = C_ALWAYS;
        u.tgt     = S_LIST1;
      end
      S_LIST3: begin
        u.emit = 1'b1;
        u.kind = KIND_END;
        u.vsel = VS_ZERO;
        u.last = 1'b1;
        u.fin  = 1'b1;
      end
      default: u.fin = 1'b1;
    endcase
    return u;
  endfunction

endpackage

// File: rtl/rpn_char_stack_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_char_stack_calculator
// Postfix stack calculator on a character stream, run by a microcoded
// sequencer over a small datapath and an iterative arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ASCII character per transfer in tdata[7:0].
//   m_axis carries results: tdata = value, tuser = result kind, tlast marks
//   the final result caused by a character.
//   After a character is taken, tready stays low while its program runs.
//   Multiply, divide and remainder wait on the one-bit-per-cycle shift-add /
//   shift-subtract unit, and a listing hands out the stack words one by one.
//   The next character is taken in the cycle after the last step, while the
//   last result may still sit in the output register.
//   If m_axis_tready stays low, a step that hands out a result waits, so the
//   whole program stalls with no result lost.
//   Reset (synchronous, active high) empties the stack and clears the
//   accumulator, overflow flag and comment mode; stack words are not cleared.
// ----------------------------------------------------------------------------
module rpn_char_stack_calculator #(
  parameter int STACK_DEPTH = 8,
  parameter int WORD_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value
  output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
  output logic        m_axis_tlast
);

  logic                  in_go;
  logic                  seq_busy;
  logic                  out_free;
  logic                  alu_busy;
  logic [WORD_WIDTH-1:0] alu_res;
  logic [WORD_WIDTH-1:0] alu_a;
  logic [WORD_WIDTH-1:0] alu_b;
  rpn_pkg::alu_req_t     alu_req;
  rpn_pkg::ctl_t         ctl;
  rpn_pkg::stat_t        stat;
  rpn_pkg::emit_t        emit;

  rpn_pkg::kind_t        out_kind;
  logic [31:0]           out_value;
  logic                  out_last;
  logic                  out_valid;

  assign s_axis_tready = !seq_busy;
  assign in_go         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  rpn_seq u_seq (
    .rst      (rst),
    .clk      (clk),
    .in_go    (in_go),
    .in_ch    (s_axis_tdata),
    .out_free (out_free),
    .alu_busy (alu_busy),
    .stat     (stat),
    .busy     (seq_busy),
    .ctl      (ctl)
  );

  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dp (
    .rst     (rst),
    .clk     (clk),
    .in_go   (in_go),
    .in_ch   (s_axis_tdata),
    .ctl     (ctl),
    .alu_res (alu_res),
    .alu_req (alu_req),
    .alu_a   (alu_a),
    .alu_b   (alu_b),
    .stat    (stat),
    .emit    (emit)
  );

  rpn_alu #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_alu (
    .rst  (rst),
    .clk  (clk),
    .req  (alu_req),
    .a    (alu_a),
    .b    (alu_b),
    .busy (alu_busy),
    .res  (alu_res)
  );

  // Output register; the sequencer only emits when it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_kind  <= emit.kind;
      out_value <= emit.value;
      out_last  <= emit.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

// File: rtl/rpn_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_seq
// Step counter of the control store: decodes each character to a program
// entry, steps through the program and resolves conditional jumps.
// ----------------------------------------------------------------------------
module rpn_seq (
  input  logic                rst,
  input  logic                clk,
  input  logic                in_go,
  input  logic [7:0]          in_ch,
  input  logic                out_free,
  input  logic                alu_busy,
  input  rpn_pkg::stat_t      stat,
  output logic                busy,
  output rpn_pkg::ctl_t       ctl
);

  logic [rpn_pkg::PC_W-1:0] pc;
  logic                     comment;
  rpn_pkg::op_t             op;
  rpn_pkg::ucw_t            u;
  logic                     stall;
  logic                     en;
  logic                     take;

  assign op    = rpn_pkg::decode_char(in_ch, comment);
  assign u     = rpn_pkg::ucode(pc);
  // A step that hands out a result waits until the output register is free.
  assign stall = busy && u.emit && !out_free;
  assign en    = busy && !stall;

  assign ctl.en = en;
  assign ctl.u  = u;

  always_comb begin
    unique case (u.cond)
      rpn_pkg::C_NEVER:     take = 1'b0;
      rpn_pkg::C_ALWAYS:    take = 1'b1;
      rpn_pkg::C_NO_OVF:    take = !stat.ovf;
      rpn_pkg::C_LIST_DONE: take = stat.list_done;
      rpn_pkg::C_ALU_BUSY:  take = alu_busy;
      default:              take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= rpn_pkg::S_DONE;
      busy    <= 1'b0;
      comment <= 1'b0;
    end else if (in_go) begin
      pc   <= rpn_pkg::entry_of(op);
      busy <= 1'b1;
      if (in_ch == rpn_pkg::CH_NL) begin
        comment <= 1'b0;
      end else if (op == rpn_pkg::OP_COMMENT) begin
        comment <= 1'b1;
      end
    end else if (en) begin
      priority if (take) begin
        pc <= u.tgt;
      end else if (u.fin) begin
        busy <= 1'b0;
      end else begin
        pc <= pc + 5'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_stall_holds_pc: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(pc))
    else $error("program counter moved during an output stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_go |-> !busy)
    else $error("character taken while a program is running");
`endif

endmodule

// File: rtl/rpn_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_alu
// Iterative multiply and signed divide/remainder unit, one bit per cycle:
// shift-add for the product, restoring shift-subtract on magnitudes for the
// quotient and remainder, then a sign fix-up cycle.
// ----------------------------------------------------------------------------
module rpn_alu #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  rst,
  input  logic                  clk,
  input  rpn_pkg::alu_req_t     req,
  input  logic [WORD_WIDTH-1:0] a,
  input  logic [WORD_WIDTH-1:0] b,
  output logic                  busy,
  output logic [WORD_WIDTH-1:0] res
);

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W);

  typedef enum logic [2:0] {
    AS_IDLE = 3'b001,
    AS_RUN  = 3'b010,
    AS_FIX  = 3'b100
  } alu_state_t;

  alu_state_t       state;
  rpn_pkg::alu_op_t op_r;
  logic [CW-1:0]    cnt;
  logic [W-1:0]     part;
  logic [W-1:0]     qr;
  logic [W-1:0]     dr;
  logic [W-1:0]     dvd;
  logic             neg_q;
  logic             neg_r;
  logic             zdiv;

  logic [W-1:0]     a_mag;
  logic [W-1:0]     b_mag;
  logic [W:0]       trial;
  logic             start;

  assign start = req.start && (state == AS_IDLE);
  assign busy  = (state != AS_IDLE);
  assign a_mag = a[W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[W-1] ? (~b + 1'b1) : b;
  assign trial = {part, qr[W-1]} - {1'b0, dr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      unique case (state)
        AS_IDLE: if (start) state <= AS_RUN;
        AS_RUN:  if (cnt == '0) state <= AS_FIX;
        AS_FIX:  state <= AS_IDLE;
        default: state <= AS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= req.op;
      cnt   <= CW'(W - 1);
      part  <= '0;
      dvd   <= a;
      zdiv  <= (b == '0);
      neg_q <= a[W-1] ^ b[W-1];
      neg_r <= a[W-1];
      if (req.op == rpn_pkg::AL_MUL) begin
        dr <= a;
        qr <= b;
      end else begin
        dr <= b_mag;
        qr <= a_mag;
      end
    end else if (state == AS_RUN) begin
      cnt <= cnt - 1'b1;
      if (op_r == rpn_pkg::AL_MUL) begin
        if (qr[0]) part <= part + dr;
        dr <= dr << 1;
        qr <= qr >> 1;
      end else if (!trial[W]) begin
        part <= trial[W-1:0];
        qr   <= {qr[W-2:0], 1'b1};
      end else begin
        part <= {part[W-2:0], qr[W-1]};
        qr   <= {qr[W-2:0], 1'b0};
      end
    end else if (state == AS_FIX) begin
      unique case (op_r)
        rpn_pkg::AL_MUL: res <= part;
        rpn_pkg::AL_DIV: res <= zdiv ? '0 : (neg_q ? (~qr + 1'b1) : qr);
        rpn_pkg::AL_REM: res <= zdiv ? dvd : (neg_r ? (~part + 1'b1) : part);
        default:         res <= part;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == AS_IDLE))
    else $error("arithmetic unit started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy)
    else $error("arithmetic unit did not go busy after start");
`endif

endmodule

// File: rtl/rpn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath driven by the control word: accumulator, stack memory with a
// registered read port, depth count, overflow flag and listing index.
// ----------------------------------------------------------------------------
module rpn_dp #(
  parameter int STACK_DEPTH = 8,
  parameter int WORD_WIDTH  = 32
) (
  input  logic                  rst,
  input  logic                  clk,
  input  logic                  in_go,
  input  logic [7:0]            in_ch,
  input  rpn_pkg::ctl_t         ctl,
  input  logic [WORD_WIDTH-1:0] alu_res,
  output rpn_pkg::alu_req_t     alu_req,
  output logic [WORD_WIDTH-1:0] alu_a,
  output logic [WORD_WIDTH-1:0] alu_b,
  output rpn_pkg::stat_t        stat,
  output rpn_pkg::emit_t        emit
);

  localparam int W   = WORD_WIDTH;
  localparam int D   = STACK_DEPTH;
  localparam int DCW = $clog2(D + 1);
  localparam int AW  = (D > 1) ? $clog2(D) : 1;
  localparam logic [DCW-1:0] DFULL = DCW'(D);

  logic [W-1:0]   mem [D];
  logic [W-1:0]   rdata;
  logic [W-1:0]   acc;
  logic [DCW-1:0] depth;
  logic [DCW-1:0] idx;
  logic           ovf;
  logic           pop_empty;
  logic [3:0]     digit;

  logic           en;
  rpn_pkg::ucw_t  u;
  logic [W-1:0]   pw;
  logic [W-1:0]   psrc_val;
  logic [DCW-1:0] rd_sel;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  wr_addr;
  logic           wr_en;
  logic [W-1:0]   vsrc;
  logic [W+31:0]  vext;

  assign en = ctl.en;
  assign u  = ctl.u;

  // A pop from an empty stack yields zero.
  assign pw       = pop_empty ? '0 : rdata;
  assign psrc_val = (u.psrc == rpn_pkg::PS_DEPTH) ? W'(depth) : acc;
  assign rd_sel   = u.pop ? (depth - 1'b1) : idx;
  assign rd_addr  = rd_sel[AW-1:0];
  assign wr_addr  = depth[AW-1:0];
  assign wr_en    = en && u.push && (depth != DFULL);

  assign alu_req.start = en && u.alu_start;
  assign alu_req.op    = u.alu_op;
  assign alu_a         = acc;
  assign alu_b         = pw;

  assign stat.ovf       = ovf;
  assign stat.list_done = (idx == depth);

  always_comb begin
    unique case (u.vsel)
      rpn_pkg::VS_ZERO:  vsrc = '0;
      rpn_pkg::VS_ACC:   vsrc = acc;
      rpn_pkg::VS_RDATA: vsrc = rdata;
      default:           vsrc = '0;
    endcase
  end

  // Words narrower than the output are zero-extended, wider ones truncated.
  assign vext       = {32'b0, vsrc};
  assign emit.valid = en && u.emit;
  assign emit.kind  = u.kind;
  assign emit.value = vext[31:0];
  assign emit.last  = u.last;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= psrc_val;
    if (en && (u.pop || u.rd_idx)) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_go) digit <= in_ch[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      depth     <= '0;
      idx       <= '0;
      ovf       <= 1'b0;
      pop_empty <= 1'b0;
    end else if (en) begin
      priority if (u.clr_depth) begin
        depth <= '0;
      end else if (u.pop) begin
        pop_empty <= (depth == '0);
        if (depth != '0) depth <= depth - 1'b1;
      end else if (u.push) begin
        if (depth == DFULL) begin
          ovf <= 1'b1;
        end else begin
          depth <= depth + 1'b1;
        end
      end
      if (u.clr_ovf) ovf <= 1'b0;
      if (u.idx_clr) begin
        idx <= '0;
      end else if (u.idx_inc) begin
        idx <= idx + 1'b1;
      end
      unique case (u.acc_op)
        rpn_pkg::AO_HOLD:  acc <= acc;
        rpn_pkg::AO_DIGIT: acc <= (acc << 3) + (acc << 1) + W'(digit);
        rpn_pkg::AO_ZERO:  acc <= '0;
        rpn_pkg::AO_ADD:   acc <= acc + pw;
        rpn_pkg::AO_SUB:   acc <= acc - pw;
        rpn_pkg::AO_POPW:  acc <= pw;
        rpn_pkg::AO_ALU:   acc <= alu_res;
        default:           acc <= acc;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The listing index keeps its last value after a listing, so it is only
  // bounded by the stack size, not by the current depth.
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    (depth <= DFULL) && (idx <= DFULL))
    else $error("stack depth or listing index out of range");
`endif

endmodule

// File: tb/tb_rpn_char_stack_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_char_stack_calculator
// Self-checking bench for the postfix character calculator. Characters are
// streamed in while a behavioral copy of the calculator predicts every
// result, and a monitor compares each output transfer against the oldest
// prediction. Directed sequences hit the corner cases, and then a long
// random stream of numbers, commands, comments and noise follows, with
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_rpn_char_stack_calculator;

  localparam int STACK_SIZE   = 8;
  localparam int IDLE_PCT     = 11;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int TOTAL_ITEMS  = 330;

  typedef struct packed {
    rpn_pkg::kind_t kind;
    logic [31:0]    value;
    logic           last;
  } calc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Shadow copy of the calculator state.
  logic [31:0] shadow_stack [STACK_SIZE];
  int unsigned shadow_depth = 0;
  logic [31:0] shadow_acc = 32'd0;
  bit          shadow_ovf = 1'b0;
  bit          shadow_comment = 1'b0;

  calc_result_t results_due [$];
  calc_result_t oldest_due;
  int           errors = 0;
  int           items_sent = 0;
  bit           steady = 1'b0;
  int           pressure_req = 0;
  int           pressure_seen = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;

  rpn_char_stack_calculator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic calc_result_t make_result(input rpn_pkg::kind_t kind,
                                               input logic [31:0] value);
    calc_result_t r;
    r.kind  = kind;
    r.value = value;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic void shadow_push(input logic [31:0] word);
    if (shadow_depth >= STACK_SIZE) begin
      shadow_ovf = 1'b1;
    end else begin
      shadow_stack[shadow_depth] = word;
      shadow_depth++;
    end
  endfunction

  function automatic logic [31:0] shadow_pop();
    if (shadow_depth == 0) return 32'd0;
    shadow_depth--;
    return shadow_stack[shadow_depth];
  endfunction

  // Applies one character to the shadow state and queues the results it causes.
  task automatic apply_char(input logic [7:0] ch);
    calc_result_t produced [$];
    logic [31:0]  word;
    int           num;
    int           den;
    if (shadow_comment) begin
      if (ch != rpn_pkg::CH_NL) return;
      shadow_comment = 1'b0;
    end
    if (shadow_ovf && (ch == rpn_pkg::CH_NL)) begin
      shadow_ovf = 1'b0;
      produced.push_back(make_result(rpn_pkg::KIND_OVF, 32'd0));
    end
    if ((ch >= rpn_pkg::CH_ZERO) && (ch <= rpn_pkg::CH_NINE)) begin
      shadow_acc = shadow_acc * 32'd10 + {24'd0, ch - rpn_pkg::CH_ZERO};
      return;
    end
    case (ch)
      rpn_pkg::CH_COMMA: begin
        shadow_push(shadow_acc);
        shadow_acc = 32'd0;
      end
      rpn_pkg::CH_LOWER_P: produced.push_back(make_result(rpn_pkg::KIND_VALUE, shadow_acc));
      rpn_pkg::CH_LOWER_F: begin
        for (int i = 0; i < shadow_depth; i++) begin
          produced.push_back(make_result(rpn_pkg::KIND_WORD, shadow_stack[i]));
        end
        produced.push_back(make_result(rpn_pkg::KIND_END, 32'd0));
      end
      rpn_pkg::CH_PLUS:  shadow_acc = shadow_acc + shadow_pop();
      rpn_pkg::CH_MINUS: shadow_acc = shadow_acc - shadow_pop();
      rpn_pkg::CH_STAR:  shadow_acc = shadow_acc * shadow_pop();
      rpn_pkg::CH_SLASH: begin
        word = shadow_pop();
        if (word == 32'd0) begin
          shadow_acc = 32'd0;
        end else if (word == 32'hFFFF_FFFF) begin
          shadow_acc = 32'd0 - shadow_acc;
        end else begin
          num = shadow_acc;
          den = word;
          shadow_acc = num / den;
        end
      end
      rpn_pkg::CH_PERCENT: begin
        word = shadow_pop();
        if (word == 32'hFFFF_FFFF) begin
          shadow_acc = 32'd0;
        end else if (word != 32'd0) begin
          num = shadow_acc;
          den = word;
          shadow_acc = num % den;
        end
      end
      rpn_pkg::CH_LOWER_C: shadow_depth = 0;
      rpn_pkg::CH_LOWER_D: shadow_push(shadow_acc);
      rpn_pkg::CH_LOWER_R: begin
        word = shadow_pop();
        shadow_push(shadow_acc);
        shadow_acc = word;
      end
      rpn_pkg::CH_LOWER_Z: shadow_push(32'(shadow_depth));
      rpn_pkg::CH_UPPER_C: shadow_ovf = 1'b0;
      rpn_pkg::CH_HASH:    shadow_comment = 1'b1;
      rpn_pkg::CH_NL, rpn_pkg::CH_SPACE: ;
      default: produced.push_back(make_result(rpn_pkg::KIND_UNKNOWN, 32'd0));
    endcase
    if (produced.size() > 0) produced[produced.size() - 1].last = 1'b1;
    foreach (produced[i]) results_due.push_back(produced[i]);
  endtask

  // One input transfer; tvalid stays high afterwards unless the next call idles.
  task automatic send_char(input logic [7:0] ch);
    while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    apply_char(ch);
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) send_char(text[i]);
  endtask

  function automatic logic [7:0] command_char(input int unsigned idx);
    case (idx)
      0:       return rpn_pkg::CH_COMMA;
      1:       return rpn_pkg::CH_LOWER_D;
      2:       return rpn_pkg::CH_LOWER_Z;
      3:       return rpn_pkg::CH_PLUS;
      4:       return rpn_pkg::CH_MINUS;
      5:       return rpn_pkg::CH_STAR;
      6:       return rpn_pkg::CH_SLASH;
      7:       return rpn_pkg::CH_PERCENT;
      8:       return rpn_pkg::CH_LOWER_R;
      9:       return rpn_pkg::CH_LOWER_P;
      10:      return rpn_pkg::CH_LOWER_F;
      11:      return rpn_pkg::CH_NL;
      12:      return rpn_pkg::CH_SPACE;
      default: return rpn_pkg::CH_UPPER_C;
    endcase
  endfunction

  task automatic send_random_token();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // Mostly short numbers; now and then a long one that may wrap.
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 3);
      repeat (len) send_char(rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      send_char(($urandom_range(0, 3) == 0) ? rpn_pkg::CH_LOWER_D : rpn_pkg::CH_COMMA);
    end else if (pick < 82) begin
      send_char(command_char($urandom_range(0, 13)));
    end else if (pick < 85) begin
      send_char(rpn_pkg::CH_LOWER_C);
    end else if (pick < 89) begin
      send_char(rpn_pkg::CH_HASH);
      repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(0, 255)));
      send_char(rpn_pkg::CH_NL);
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Empty-stack pops, divide and remainder by zero, most negative over -1.
  task automatic test_division_corners();
    send_text("1,-,2147483648/p%/p");
  endtask

  // Fill the stack, overflow it, list it, and exercise the flag commands.
  task automatic test_stack_limits();
    send_text("zzzzzzzzzfCz\nr+*cf");
  endtask

  // Comments, spaces, unknown bytes and the byte extremes.
  task automatic test_comment_and_unknown();
    send_text("# 9p\nx");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    send_text(" 7dp");
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (40) send_random_token();
    steady = 1'b0;
  endtask

  // The receiver holds off while listings and prints keep arriving.
  task automatic test_output_backpressure();
    pressure_req++;
    send_text("5,6,zf");
    repeat (6) send_text("pf");
  endtask

  // Tops the run up to the planned number of input transfers.
  task automatic test_random_stream();
    while (items_sent < TOTAL_ITEMS) send_random_token();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_division_corners();
    test_stack_limits();
    test_comment_and_unknown();
    test_back_to_back();
    test_output_backpressure();
    test_random_stream();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_rpn_char_stack_calculator: done, clean");
    end else begin
      $display("tb_rpn_char_stack_calculator: done, errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (pressure_seen != pressure_req) begin
      pressure_seen = pressure_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: kind %0d value %0d last %0d", $time,
                 m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
      end else begin
        oldest_due = results_due.pop_front();
        if ((m_axis_tuser != oldest_due.kind) || (m_axis_tdata != oldest_due.value) ||
            (m_axis_tlast != oldest_due.last)) begin
          errors++;
          $display("%0t: mismatch: expected kind %0d value %0d last %0d,",
                   $time, oldest_due.kind, $signed(oldest_due.value), oldest_due.last,
                   " actual kind %0d value %0d last %0d",
                   m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_rpn_char_stack_calculator: done, errors");
      $finish;
    end
  end

endmodule
